### rtl/pgl_pkg.sv
// Shared constants, types and action codes for the partition group list manager.
`default_nettype none
package pgl_pkg;

  // Node store depth; the null link and the full group count both equal it.
  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;  // node / group index
  localparam int unsigned LW = $clog2(MAX_NODES + 1);                    // link or count

  localparam logic [LW-1:0] NODE_NIL = LW'(MAX_NODES);
  localparam logic [LW-1:0] CNT_MAX  = LW'(MAX_NODES);

  // Fixed field widths of the beats
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned NODE_W = 11;
  localparam int unsigned GSEL_W = 10;
  localparam int unsigned GRP_W  = 10;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned MEM_W  = 10;

  localparam int unsigned CMPW = (LW > NODE_W) ? LW : NODE_W;

  localparam int unsigned S_FIELDS_W = 2 * NODE_W + GSEL_W;
  localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INIT   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CREATE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MOVE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SAME   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_INFO   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PAIR   = 3'd5;

  typedef struct packed {
    logic [NW-1:0] grp;
    logic [LW-1:0] prev;
    logic [LW-1:0] next;
  } node_word_t;

  typedef struct packed {
    logic [LW-1:0] head;
    logic [LW-1:0] members;
  } group_word_t;

  localparam int unsigned NODE_WORD_W  = $bits(node_word_t);
  localparam int unsigned GROUP_WORD_W = $bits(group_word_t);

  typedef struct packed {
    logic             we;
    logic [NW-1:0]    waddr;
    node_word_t       wmask;
    node_word_t       wdata;
    logic [NW-1:0]    raddr;
  } node_req_t;

  typedef struct packed {
    logic             we;
    logic [NW-1:0]    waddr;
    group_word_t      wmask;
    group_word_t      wdata;
    logic [NW-1:0]    raddr;
  } group_req_t;

  // Result beat, same_group in the lowest bit
  typedef struct packed {
    logic [CNT_W-1:0] groups_used;
    logic             error;
    logic             found;
    logic [MEM_W-1:0] second_member;
    logic [MEM_W-1:0] first_member;
    logic [CNT_W-1:0] size_of_group;
    logic [GRP_W-1:0] group_of_node;
    logic             same_group;
  } res_t;

  localparam int unsigned RES_W     = $bits(res_t);
  localparam int unsigned M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage
`default_nettype wire

### rtl/partition_group_list_manager_top.sv
// Top level of the partition group list manager: memories, sequencer and output register.
//
//  channel  direction  handshake                      payload
//  s_axis   in         s_axis_tvalid / s_axis_tready  tdata: node_a, node_b, group_sel
//                                                     tuser: action
//  m_axis   out        m_axis_tvalid / m_axis_tready  tdata: one result beat per action
//  cfg      in         cfg_valid_i / cfg_ready_o      node_count, applied by init
//
// Each input beat runs to completion before the next is taken; accesses to the node memory
// go one after another through its single read port. Init writes one node entry and one
// group entry per cycle over the whole store.
// Reset: no clearing pass; until the first init every node index is out of range and
// the group memory reads as empty. A new beat is taken while a result waits in the
// output register; the sequencer holds in its done state only if that register is full.
`default_nettype none
module partition_group_list_manager_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // node_a [10:0], node_b [21:11], group_sel [31:22]
  input  wire logic [pgl_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // action [2:0]
  input  wire logic [pgl_pkg::ACT_W-1:0]      s_axis_tuser,
  input  wire logic                           s_axis_tvalid,
  output      logic                           s_axis_tready,
  // same_group [0], group_of_node [10:1], size_of_group [21:11], first_member [31:22],
  // second_member [41:32], found [42], error [43], groups_used [54:44], zero pad above
  output      logic [pgl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output      logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic [pgl_pkg::CNT_W-1:0]      cfg_data_i,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o
);
  import pgl_pkg::*;

  node_req_t   node_req;
  node_word_t  node_rd;
  group_req_t  group_req;
  group_word_t group_rd;
  logic        res_valid;
  logic        res_ready;
  res_t        res;
  res_t        out_res;

  // register write is always taken; the host must make its writes only while idle, and the block does not enforce this
  assign cfg_ready_o = 1'b1;

  // per-node word: group, prev link, next link
  pgl_ram #(
    .WIDTH (NODE_WORD_W),
    .DEPTH (MAX_NODES)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_req.we),
    .waddr_i (node_req.waddr),
    .wmask_i (node_req.wmask),
    .wdata_i (node_req.wdata),
    .raddr_i (node_req.raddr),
    .rdata_o (node_rd)
  );

  // per-group word: head, member count
  pgl_ram #(
    .WIDTH (GROUP_WORD_W),
    .DEPTH (MAX_NODES)
  ) u_group_ram (
    .clk_i   (clk_i),
    .we_i    (group_req.we),
    .waddr_i (group_req.waddr),
    .wmask_i (group_req.wmask),
    .wdata_i (group_req.wdata),
    .raddr_i (group_req.raddr),
    .rdata_o (group_rd)
  );

  pgl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .node_a_i    (s_axis_tdata[NODE_W-1:0]),
    .node_b_i    (s_axis_tdata[2*NODE_W-1:NODE_W]),
    .group_sel_i (s_axis_tdata[S_FIELDS_W-1:2*NODE_W]),
    .node_req_o  (node_req),
    .node_rd_i   (node_rd),
    .group_req_o (group_req),
    .group_rd_i  (group_rd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  pgl_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (res_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = M_TDATA_W'(out_res);

endmodule
`default_nettype wire

### rtl/pgl_ram.sv
// Generic single-port-write, single-port-read RAM with bit mask and registered read.
`default_nettype none
module pgl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wmask_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                             rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [AW-1:0]    unused_w;

  assign unused_w = waddr_i;

  // read returns the old word on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[unused_w] <= (mem_q[unused_w] & ~wmask_i) | (wdata_i & wmask_i);
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### rtl/pgl_seq.sv
// Action sequencer: read-modify-write of the node and group memories per action.
`default_nettype none
module pgl_seq (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [pgl_pkg::CNT_W-1:0]  cfg_data_i,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [pgl_pkg::ACT_W-1:0]  action_i,
  input  wire logic [pgl_pkg::NODE_W-1:0] node_a_i,
  input  wire logic [pgl_pkg::NODE_W-1:0] node_b_i,
  input  wire logic [pgl_pkg::GSEL_W-1:0] group_sel_i,
  output      pgl_pkg::node_req_t         node_req_o,
  input  wire pgl_pkg::node_word_t        node_rd_i,
  output      pgl_pkg::group_req_t        group_req_o,
  input  wire pgl_pkg::group_word_t       group_rd_i,
  output      logic                       res_valid_o,
  input  wire logic                       res_ready_i,
  output      pgl_pkg::res_t              res_o
);
  import pgl_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_INIT = 5'd1;
  localparam logic [4:0] S_MV_B = 5'd2;
  localparam logic [4:0] S_UL_A = 5'd3;
  localparam logic [4:0] S_UL_G = 5'd4;
  localparam logic [4:0] S_UL_N = 5'd5;
  localparam logic [4:0] S_LK_G = 5'd6;
  localparam logic [4:0] S_LK_N = 5'd7;
  localparam logic [4:0] S_SG_A = 5'd8;
  localparam logic [4:0] S_SG_B = 5'd9;
  localparam logic [4:0] S_SG_G = 5'd10;
  localparam logic [4:0] S_IF_A = 5'd11;
  localparam logic [4:0] S_IF_G = 5'd12;
  localparam logic [4:0] S_IF_N = 5'd13;
  localparam logic [4:0] S_PR_G = 5'd14;
  localparam logic [4:0] S_PR_N = 5'd15;
  localparam logic [4:0] S_DONE = 5'd16;

  logic [4:0]       state_q, state_d;
  logic [CNT_W-1:0] node_count_q, node_count_d;
  logic [LW-1:0]    active_n_q, active_n_d;
  logic [LW-1:0]    ngn_q, ngn_d;
  logic             init_done_q, init_done_d;

  logic [NW-1:0]    cnt_q, cnt_d;
  logic [NW-1:0]    a_q, a_d;
  logic [NW-1:0]    b_q, b_d;
  logic [NW-1:0]    g_q, g_d;
  logic [NW-1:0]    ga_q, ga_d;
  logic [LW-1:0]    p_q, p_d;
  logic [LW-1:0]    nx_q, nx_d;
  logic [LW-1:0]    h_q, h_d;
  logic [LW-1:0]    size_q, size_d;
  res_t             res_q, res_d;

  logic             a_ok, b_ok, gs_ok;
  logic [LW-1:0]    n_init;
  logic [LW-1:0]    cnt_ext;
  group_word_t      pair_gw;

  assign a_ok  = CMPW'(node_a_i) < CMPW'(active_n_q);
  assign b_ok  = CMPW'(node_b_i) < CMPW'(active_n_q);
  assign gs_ok = CMPW'(group_sel_i) < CMPW'(MAX_NODES);

  // node count 0 is taken as 1, large values saturate
  always_comb begin
    if (node_count_q == '0) begin
      n_init = LW'(1);
    end else if (CMPW'(node_count_q) > CMPW'(MAX_NODES)) begin
      n_init = CNT_MAX;
    end else begin
      n_init = LW'(node_count_q);
    end
  end

  assign cnt_ext = LW'(cnt_q);

  // group memory holds no content before the first init: read as empty
  always_comb begin
    if (init_done_q) begin
      pair_gw = group_rd_i;
    end else begin
      pair_gw.head    = NODE_NIL;
      pair_gw.members = '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    node_count_d = cfg_we_i ? cfg_data_i : node_count_q;
    active_n_d   = active_n_q;
    ngn_d        = ngn_q;
    init_done_d  = init_done_q;
    cnt_d        = cnt_q;
    a_d          = a_q;
    b_d          = b_q;
    g_d          = g_q;
    ga_d         = ga_q;
    p_d          = p_q;
    nx_d         = nx_q;
    h_d          = h_q;
    size_d       = size_q;
    res_d        = res_q;
    node_req_o   = '0;
    group_req_o  = '0;

    case (state_q)
      S_IDLE: begin
        node_req_o.raddr  = (action_i == ACT_MOVE) ? NW'(node_b_i) : NW'(node_a_i);
        group_req_o.raddr = NW'(group_sel_i);
        if (in_valid_i) begin
          a_d   = NW'(node_a_i);
          b_d   = NW'(node_b_i);
          res_d = '0;
          case (action_i)
            ACT_INIT: begin
              active_n_d = n_init;
              ngn_d      = LW'(1);
              cnt_d      = '0;
              state_d    = S_INIT;
            end
            ACT_CREATE: begin
              if (a_ok && (ngn_q != CNT_MAX)) begin
                g_d     = NW'(ngn_q);
                ngn_d   = ngn_q + LW'(1);
                state_d = S_UL_A;
              end else begin
                res_d.error = 1'b1;
                state_d     = S_DONE;
              end
            end
            ACT_MOVE: begin
              if (a_ok && b_ok) begin
                state_d = S_MV_B;
              end else begin
                res_d.error = 1'b1;
                state_d     = S_DONE;
              end
            end
            ACT_SAME: begin
              if (a_ok && b_ok) begin
                state_d = S_SG_A;
              end else begin
                res_d.error = 1'b1;
                state_d     = S_DONE;
              end
            end
            ACT_INFO: begin
              if (a_ok) begin
                state_d = S_IF_A;
              end else begin
                res_d.error = 1'b1;
                state_d     = S_DONE;
              end
            end
            ACT_PAIR: begin
              res_d.group_of_node = GRP_W'(group_sel_i);
              if (gs_ok) begin
                state_d = S_PR_G;
              end else begin
                res_d.error = 1'b1;
                state_d     = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // one entry of both memories per cycle
      S_INIT: begin
        node_req_o.we         = 1'b1;
        node_req_o.waddr      = cnt_q;
        node_req_o.wmask      = '1;
        node_req_o.wdata.grp  = '0;
        node_req_o.wdata.prev = ((cnt_q != '0) && (cnt_ext < active_n_q)) ?
                                (cnt_ext - LW'(1)) : NODE_NIL;
        node_req_o.wdata.next = ((cnt_ext + LW'(1)) < active_n_q) ?
                                (cnt_ext + LW'(1)) : NODE_NIL;
        group_req_o.we        = 1'b1;
        group_req_o.waddr     = cnt_q;
        group_req_o.wmask     = '1;
        if (cnt_q == '0) begin
          group_req_o.wdata.head    = '0;
          group_req_o.wdata.members = active_n_q;
        end else begin
          group_req_o.wdata.head    = NODE_NIL;
          group_req_o.wdata.members = '0;
        end
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NW'(MAX_NODES - 1)) begin
          init_done_d         = 1'b1;
          res_d.size_of_group = CNT_W'(active_n_q);
          state_d             = S_DONE;
        end
      end

      S_MV_B: begin
        g_d              = node_rd_i.grp;
        node_req_o.raddr = a_q;
        state_d          = S_UL_A;
      end

      S_UL_A: begin
        ga_d              = node_rd_i.grp;
        p_d               = node_rd_i.prev;
        nx_d              = node_rd_i.next;
        group_req_o.raddr = node_rd_i.grp;
        state_d           = S_UL_G;
      end

      // unlink: count down, fix head or predecessor
      S_UL_G: begin
        group_req_o.we                = 1'b1;
        group_req_o.waddr             = ga_q;
        group_req_o.wdata.head        = nx_q;
        group_req_o.wdata.members     = (group_rd_i.members != '0) ?
                                        (group_rd_i.members - LW'(1)) : group_rd_i.members;
        group_req_o.wmask.members     = '1;
        group_req_o.wmask.head        = (p_q == NODE_NIL) ? '1 : '0;
        if (p_q != NODE_NIL) begin
          node_req_o.we         = 1'b1;
          node_req_o.waddr      = NW'(p_q);
          node_req_o.wmask.next = '1;
          node_req_o.wdata.next = nx_q;
        end
        state_d = S_UL_N;
      end

      S_UL_N: begin
        if (nx_q != NODE_NIL) begin
          node_req_o.we         = 1'b1;
          node_req_o.waddr      = NW'(nx_q);
          node_req_o.wmask.prev = '1;
          node_req_o.wdata.prev = p_q;
        end
        group_req_o.raddr = g_q;
        state_d           = S_LK_G;
      end

      // link at head of the target group
      S_LK_G: begin
        h_d                       = group_rd_i.head;
        size_d                    = group_rd_i.members + LW'(1);
        group_req_o.we            = 1'b1;
        group_req_o.waddr         = g_q;
        group_req_o.wmask         = '1;
        group_req_o.wdata.head    = LW'(a_q);
        group_req_o.wdata.members = group_rd_i.members + LW'(1);
        node_req_o.we             = 1'b1;
        node_req_o.waddr          = a_q;
        node_req_o.wmask          = '1;
        node_req_o.wdata.grp      = g_q;
        node_req_o.wdata.prev     = NODE_NIL;
        node_req_o.wdata.next     = group_rd_i.head;
        state_d                   = S_LK_N;
      end

      S_LK_N: begin
        if (h_q != NODE_NIL) begin
          node_req_o.we         = 1'b1;
          node_req_o.waddr      = NW'(h_q);
          node_req_o.wmask.prev = '1;
          node_req_o.wdata.prev = LW'(a_q);
        end
        res_d.group_of_node = GRP_W'(g_q);
        res_d.size_of_group = CNT_W'(size_q);
        res_d.first_member  = MEM_W'(a_q);
        state_d             = S_DONE;
      end

      S_SG_A: begin
        ga_d             = node_rd_i.grp;
        node_req_o.raddr = b_q;
        state_d          = S_SG_B;
      end

      S_SG_B: begin
        res_d.same_group    = (node_rd_i.grp == ga_q);
        res_d.group_of_node = GRP_W'(ga_q);
        group_req_o.raddr   = ga_q;
        state_d             = S_SG_G;
      end

      S_SG_G: begin
        res_d.size_of_group = CNT_W'(group_rd_i.members);
        state_d             = S_DONE;
      end

      S_IF_A: begin
        ga_d              = node_rd_i.grp;
        group_req_o.raddr = node_rd_i.grp;
        state_d           = S_IF_G;
      end

      S_IF_G: begin
        res_d.group_of_node = GRP_W'(ga_q);
        res_d.size_of_group = CNT_W'(group_rd_i.members);
        if (group_rd_i.head == NODE_NIL) begin
          res_d.error = 1'b1;
          state_d     = S_DONE;
        end else if (group_rd_i.head != LW'(a_q)) begin
          res_d.first_member = MEM_W'(group_rd_i.head);
          state_d            = S_DONE;
        end else begin
          // node is the head: report its successor
          node_req_o.raddr = NW'(group_rd_i.head);
          state_d          = S_IF_N;
        end
      end

      S_IF_N: begin
        if (node_rd_i.next == NODE_NIL) begin
          res_d.error = 1'b1;
        end else begin
          res_d.first_member = MEM_W'(node_rd_i.next);
        end
        state_d = S_DONE;
      end

      S_PR_G: begin
        res_d.size_of_group = CNT_W'(pair_gw.members);
        if (pair_gw.head == NODE_NIL) begin
          res_d.error = 1'b1;
          state_d     = S_DONE;
        end else begin
          h_d              = pair_gw.head;
          node_req_o.raddr = NW'(pair_gw.head);
          state_d          = S_PR_N;
        end
      end

      S_PR_N: begin
        if (node_rd_i.next != NODE_NIL) begin
          res_d.first_member  = MEM_W'(h_q);
          res_d.second_member = MEM_W'(node_rd_i.next);
          res_d.found         = 1'b1;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= NODE_COUNT_RST;
      active_n_q   <= '0;
      ngn_q        <= LW'(1);
      init_done_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      active_n_q   <= active_n_d;
      ngn_q        <= ngn_d;
      init_done_q  <= init_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    a_q    <= a_d;
    b_q    <= b_d;
    g_q    <= g_d;
    ga_q   <= ga_d;
    p_q    <= p_d;
    nx_q   <= nx_d;
    h_q    <= h_d;
    size_q <= size_d;
    res_q  <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o             = res_q;
    res_o.groups_used = CNT_W'(ngn_q);
  end

endmodule
`default_nettype wire

### rtl/pgl_obuf.sv
// One-entry output register between the sequencer and the result stream.
`default_nettype none
module pgl_obuf (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire pgl_pkg::res_t in_data_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      pgl_pkg::res_t out_data_o
);
  import pgl_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

### rtl/pgl_checker.sv
// Port-level checker for the partition group list manager, bound to the top level.
`default_nettype none
module pgl_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic [pgl_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready
);
  import pgl_pkg::*;

  res_t r;
  assign r = res_t'(m_axis_tdata[RES_W-1:0]);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // an accepted beat takes the sequencer busy, so input ready is low in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // a new result only leaves the done state, where input ready is low
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without a finished action");

  // a found pair is two distinct members and no error
  a_pair_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && r.found |-> !r.error && (r.first_member != r.second_member))
    else $error("pair result inconsistent");

endmodule

bind partition_group_list_manager_top pgl_checker u_pgl_checker (.*);
`default_nettype wire

### tb/sv/pgl_result_checker.sv
// Watches the partition group list manager channels, models the group store and checks each result beat.
`timescale 1ns / 1ps
module pgl_result_checker
  import pgl_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [S_TDATA_W-1:0]   s_tdata_i,
  input  wire logic [ACT_W-1:0]       s_tuser_i,
  input  wire logic                   s_tvalid_i,
  input  wire logic                   s_tready_i,
  input  wire logic [M_TDATA_W-1:0]   m_tdata_i,
  input  wire logic                   m_tvalid_i,
  input  wire logic                   m_tready_i,
  input  wire logic [CNT_W-1:0]       cfg_data_i,
  input  wire logic                   cfg_valid_i,
  input  wire logic                   cfg_ready_i,
  output      int                     fail_count_o,
  output      int                     pending_o
);

  // Shadow copy of the group store
  logic [LW-1:0] nxt_lnk [MAX_NODES];
  logic [LW-1:0] prv_lnk [MAX_NODES];
  logic [NW-1:0] grp_of  [MAX_NODES];
  logic [LW-1:0] grp_hd  [MAX_NODES];
  logic [LW-1:0] grp_cnt [MAX_NODES];
  logic [CNT_W-1:0] grp_next;
  logic [CNT_W-1:0] live_nodes;
  logic [CNT_W-1:0] cfg_count;

  res_t predicted_results [$];
  int   mismatches;

  function automatic void detach_node(input logic [NW-1:0] v);
    logic [NW-1:0] g;
    logic [LW-1:0] p, nx;
    g  = grp_of[v];
    p  = prv_lnk[v];
    nx = nxt_lnk[v];
    if (grp_cnt[g] > 0) grp_cnt[g] = grp_cnt[g] - 1'b1;
    if (p < NODE_NIL) nxt_lnk[p[NW-1:0]] = nx;
    else grp_hd[g] = nx;
    if (nx < NODE_NIL) prv_lnk[nx[NW-1:0]] = p;
  endfunction

  function automatic void push_head(input logic [NW-1:0] v, input logic [NW-1:0] g);
    logic [LW-1:0] h;
    h = grp_hd[g];
    grp_cnt[g] = grp_cnt[g] + 1'b1;
    grp_of[v]  = g;
    prv_lnk[v] = NODE_NIL;
    nxt_lnk[v] = h;
    grp_hd[g]  = LW'(v);
    if (h < NODE_NIL) prv_lnk[h[NW-1:0]] = LW'(v);
  endfunction

  function automatic res_t apply_action(input logic [ACT_W-1:0] act,
                                        input logic [NODE_W-1:0] a,
                                        input logic [NODE_W-1:0] b,
                                        input logic [GSEL_W-1:0] gs);
    res_t r;
    logic [CNT_W-1:0] n;
    logic [NW-1:0] g;
    logic [LW-1:0] h, nx;
    r = '0;
    case (act)
      ACT_INIT: begin
        n = (cfg_count == 0) ? CNT_W'(1) : ((cfg_count > CNT_MAX) ? CNT_MAX : cfg_count);
        live_nodes = n;
        for (int i = 0; i < MAX_NODES; i++) begin
          grp_hd[i]  = NODE_NIL;
          grp_cnt[i] = '0;
          grp_of[i]  = '0;
          prv_lnk[i] = (i > 0 && i < n) ? LW'(i - 1) : NODE_NIL;
          nxt_lnk[i] = (i + 1 < n) ? LW'(i + 1) : NODE_NIL;
        end
        grp_hd[0]  = '0;
        grp_cnt[0] = n;
        grp_next   = CNT_W'(1);
        r.size_of_group = n;
      end
      ACT_CREATE: begin
        if (a >= live_nodes || grp_next >= CNT_MAX) begin
          r.error = 1'b1;
        end else begin
          g = grp_next[NW-1:0];
          grp_next = grp_next + 1'b1;
          detach_node(a[NW-1:0]);
          push_head(a[NW-1:0], g);
          r.group_of_node = g;
          r.size_of_group = grp_cnt[g];
          r.first_member  = a[MEM_W-1:0];
        end
      end
      ACT_MOVE: begin
        if (a >= live_nodes || b >= live_nodes) begin
          r.error = 1'b1;
        end else begin
          g = grp_of[b[NW-1:0]];
          detach_node(a[NW-1:0]);
          push_head(a[NW-1:0], g);
          r.group_of_node = g;
          r.size_of_group = grp_cnt[g];
          r.first_member  = grp_hd[g][MEM_W-1:0];
        end
      end
      ACT_SAME: begin
        if (a >= live_nodes || b >= live_nodes) begin
          r.error = 1'b1;
        end else begin
          g = grp_of[a[NW-1:0]];
          r.same_group    = (g == grp_of[b[NW-1:0]]);
          r.group_of_node = g;
          r.size_of_group = grp_cnt[g];
        end
      end
      ACT_INFO: begin
        if (a >= live_nodes) begin
          r.error = 1'b1;
        end else begin
          g = grp_of[a[NW-1:0]];
          r.group_of_node = g;
          r.size_of_group = grp_cnt[g];
          h = grp_hd[g];
          if (h >= NODE_NIL) begin
            r.error = 1'b1;
          end else if (h != a) begin
            r.first_member = h[MEM_W-1:0];
          end else begin
            nx = nxt_lnk[h[NW-1:0]];
            if (nx >= NODE_NIL) r.error = 1'b1;
            else r.first_member = nx[MEM_W-1:0];
          end
        end
      end
      ACT_PAIR: begin
        r.group_of_node = gs;
        r.size_of_group = grp_cnt[gs];
        h = grp_hd[gs];
        if (h >= NODE_NIL) begin
          r.error = 1'b1;
        end else begin
          nx = nxt_lnk[h[NW-1:0]];
          if (nx < NODE_NIL) begin
            r.first_member  = h[MEM_W-1:0];
            r.second_member = nx[MEM_W-1:0];
            r.found         = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.groups_used = grp_next;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input int unsigned want,
                               input int unsigned got);
    if (mismatches < 10)
      $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want, got, pred;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_NODES; i++) begin
        nxt_lnk[i] = NODE_NIL;
        prv_lnk[i] = NODE_NIL;
        grp_of[i]  = '0;
        grp_hd[i]  = NODE_NIL;
        grp_cnt[i] = '0;
      end
      grp_next   = CNT_W'(1);
      live_nodes = '0;
      cfg_count  = NODE_COUNT_RST;
      predicted_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) cfg_count = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        pred = apply_action(s_tuser_i, s_tdata_i[NODE_W-1:0],
                            s_tdata_i[2*NODE_W-1:NODE_W],
                            s_tdata_i[S_FIELDS_W-1:2*NODE_W]);
        predicted_results.insert(predicted_results.size(), pred);
      end
      if (m_tvalid_i && m_tready_i) begin
        got = res_t'(m_tdata_i[RES_W-1:0]);
        if (predicted_results.size() == 0) begin
          if (mismatches < 10) $display("result beat with nothing predicted: %h", m_tdata_i);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (got.same_group !== want.same_group)
            note_mismatch("same_group", want.same_group, got.same_group);
          if (got.group_of_node !== want.group_of_node)
            note_mismatch("group_of_node", want.group_of_node, got.group_of_node);
          if (got.size_of_group !== want.size_of_group)
            note_mismatch("size_of_group", want.size_of_group, got.size_of_group);
          if (got.first_member !== want.first_member)
            note_mismatch("first_member", want.first_member, got.first_member);
          if (got.second_member !== want.second_member)
            note_mismatch("second_member", want.second_member, got.second_member);
          if (got.found !== want.found)
            note_mismatch("found", want.found, got.found);
          if (got.error !== want.error)
            note_mismatch("error", want.error, got.error);
          if (got.groups_used !== want.groups_used)
            note_mismatch("groups_used", want.groups_used, got.groups_used);
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= predicted_results.size();
    end
  end

endmodule

### tb/sv/partition_group_list_manager_top_test.sv
// Stimulus, clock, reset and verdict for the partition group list manager testbench.
`timescale 1ns / 1ps
module partition_group_list_manager_top_test;
  import pgl_pkg::*;

  // Action codes the block leaves unused
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  // Receiver stall patterns
  localparam int RX_OPEN   = 0;  // always ready
  localparam int RX_SPARSE = 1;  // ready about three times in four, at random
  localparam int RX_BURSTY = 2;  // long stall runs, short ready runs

  // Every input starts at a known value; reset is held low from time zero.
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [ACT_W-1:0]      s_axis_tuser  = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [CNT_W-1:0]      cfg_data_i    = '0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;

  int mismatch_total;
  int results_owed;

  // Sender state: beats left in the current burst, active node count for
  // picking in-range indexes, and a rough count of groups handed out
  int          burst_left = 0;
  int unsigned live_n     = 0;
  int unsigned made       = 0;

  // Receiver stall pattern state
  int rx_mode      = RX_OPEN;
  int rx_mode_left = 0;
  int rx_hold      = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  partition_group_list_manager_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data_i    (cfg_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o)
  );

  pgl_result_checker u_result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .cfg_data_i   (cfg_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .fail_count_o (mismatch_total),
    .pending_o    (results_owed)
  );

  // Receiver: switches at random between stall patterns so back-pressure
  // holds the sequencer in its done state in varied ways, including
  // stretches with none at all.
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      <= $urandom_range(RX_OPEN, RX_BURSTY);
      rx_mode_left <= $urandom_range(64, 255);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: begin
        m_axis_tready <= 1'b1;
      end
      RX_SPARSE: begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (rx_hold == 0) begin
          m_axis_tready <= ~m_axis_tready;
          rx_hold <= m_axis_tready ? $urandom_range(1, 24) : $urandom_range(1, 6);
        end else begin
          rx_hold <= rx_hold - 1;
        end
      end
    endcase
  end

  // One input beat. Bursts of random length with random gaps in between;
  // a zero gap keeps tvalid high across burst boundaries.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [NODE_W-1:0] a,
                           input logic [NODE_W-1:0] b, input logic [GSEL_W-1:0] gs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_axis_tdata  <= {gs, b, a};
    s_axis_tuser  <= act;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop tvalid and hold off until every predicted result has come out.
  // The first edge lets the checker's count catch up with the last beat.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
  endtask

  // Register write while idle, followed by an init that applies it.
  task automatic start_partition(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    // same clamp the block applies at init: 0 reads as 1, saturate at the store depth
    live_n = (value == 0) ? 1 : ((value > MAX_NODES) ? MAX_NODES : value);
    made   = 0;
    send_item(ACT_INIT, '0, '0, '0);
  endtask

  // Mostly in-range indexes so lists get deep; about one in ten is noise
  // across the whole field, which also exercises the bad-index path.
  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, 2047));
    return NODE_W'($urandom_range(0, live_n - 1));
  endfunction

  task automatic send_random_item();
    int unsigned roll;
    logic [GSEL_W-1:0] gs;
    roll = $urandom_range(0, 99);
    // pair mostly targets groups that exist, sometimes any number at all
    gs = ($urandom_range(0, 7) == 0) ? GSEL_W'($urandom_range(0, 1023))
                                     : GSEL_W'($urandom_range(0, (made < 1022) ? made + 1 : 1023));
    if (roll < 3) begin
      send_item(ACT_INIT, pick_node(), pick_node(), gs);
      made = 0;
    end else if (roll < 6) begin
      send_item($urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO,
                NODE_W'($urandom_range(0, 2047)), NODE_W'($urandom_range(0, 2047)), gs);
    end else if (roll < 26) begin
      send_item(ACT_CREATE, pick_node(), pick_node(), gs);
      made++;
    end else if (roll < 51) begin
      send_item(ACT_MOVE, pick_node(), pick_node(), gs);
    end else if (roll < 66) begin
      send_item(ACT_SAME, pick_node(), pick_node(), gs);
    end else if (roll < 81) begin
      send_item(ACT_INFO, pick_node(), pick_node(), gs);
    end else begin
      send_item(ACT_PAIR, pick_node(), pick_node(), gs);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] setting;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before any init: every index is out of range and every group is empty.
    send_item(ACT_PAIR,   '0, '0, '0);
    send_item(ACT_SAME,   '0, '0, '0);
    send_item(ACT_INFO,   '0, '0, '0);
    send_item(ACT_CREATE, '0, '0, '0);
    send_item(ACT_MOVE,   '0, '0, '0);
    send_item(ACT_SPARE_LO, '0, '0, '0);

    // Largest count, saturating down to the store depth.
    start_partition(11'd2047);
    send_item(ACT_CREATE, 11'd1023, '0, '0);
    send_item(ACT_MOVE,   11'd0, 11'd1023, '0);
    send_item(ACT_SAME,   11'd1023, 11'd0, '0);
    send_item(ACT_SAME,   11'd1, 11'd2, '0);
    send_item(ACT_INFO,   11'd1, '0, '0);       // node is the head: next member reported
    send_item(ACT_INFO,   11'd2, '0, '0);       // head of its group differs from the node
    send_item(ACT_PAIR,   '0, '0, 10'd0);
    send_item(ACT_PAIR,   '0, '0, 10'd1);       // two members after the move
    send_item(ACT_PAIR,   '0, '0, 10'd1023);    // empty group
    send_item(ACT_MOVE,   11'd1023, 11'd1023, '0);  // onto its own group
    send_item(ACT_MOVE,   11'd1024, 11'd0, '0);     // bad first index
    send_item(ACT_SAME,   11'd0, 11'd2047, '0);     // bad second index
    send_item(ACT_CREATE, 11'd2047, 11'd2047, 10'd1023);
    send_item(ACT_SPARE_HI, 11'd2047, 11'd2047, 10'd1023);

    // Zero count reads as a single node.
    start_partition(11'd0);
    send_item(ACT_INFO,   11'd0, '0, '0);       // alone: no other member
    send_item(ACT_PAIR,   '0, '0, 10'd0);       // single member
    send_item(ACT_CREATE, 11'd0, '0, '0);
    send_item(ACT_INFO,   11'd0, '0, '0);
    send_item(ACT_MOVE,   11'd0, 11'd0, '0);
    send_item(ACT_MOVE,   11'd1, 11'd0, '0);

    // Random phases, each under its own node count. The first three cover
    // the remaining extremes; the rest lean toward small sets so groups
    // split and merge often.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: setting = 11'd1024;
        1: setting = 11'd1025;
        2: setting = 11'd1;
        default: setting = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 2047))
                                                       : CNT_W'($urandom_range(2, 48));
      endcase
      start_partition(setting);
      for (int k = 0; k < 51; k++) begin
        // now and then the sender drains the block completely
        if ($urandom_range(0, 39) == 0) wait_idle();
        send_random_item();
      end
    end

    // Drain, then keep watching for any stray beat before the verdict.
    wait_idle();
    repeat (MAX_NODES + 64) @(posedge clk_i);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/pgl_pkg.sv
rtl/pgl_ram.sv
rtl/pgl_seq.sv
rtl/pgl_obuf.sv
rtl/partition_group_list_manager_top.sv
rtl/pgl_checker.sv
tb/sv/pgl_result_checker.sv
tb/sv/partition_group_list_manager_top_test.sv
